[sv/mvph_pkg.sv]
`timescale 1ns / 1ps
// mvph_pkg: shared types and constants for the MPEG video picture header parser.
// No dependencies.
package mvph_pkg;

    // Start code prefix as seen in the three-byte history
    localparam logic [23:0] CODE_PREFIX = 24'h000001;
    localparam logic [23:0] HIST_RESET  = 24'hFFFFFF;

    // Start code values of interest
    localparam logic [7:0] PIC_CODE = 8'h00;
    localparam logic [7:0] SEQ_CODE = 8'hB3;

    // Picture coding types that carry vector fields
    localparam logic [2:0] TYPE_P = 3'd2;
    localparam logic [2:0] TYPE_B = 3'd3;

    // Header fields reported at frame end
    typedef struct packed {
        logic [9:0] temp_ref;
        logic [2:0] picture_type;
        logic       sequence_start;
        logic       full_pel_forward;
        logic [2:0] forward_code;
        logic       full_pel_backward;
        logic [2:0] backward_code;
    } fields_t;

endpackage

[sv/mvph_parser.sv]
`timescale 1ns / 1ps
// mvph_parser: start code detection and picture header capture state.
// Depends on mvph_pkg.
module mvph_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output mvph_pkg::fields_t fields
);
    import mvph_pkg::*;

    // header position: which header byte is due next
    localparam logic [2:0] POS_IDLE = 3'd0;
    localparam logic [2:0] POS_B0   = 3'd1;
    localparam logic [2:0] POS_B1   = 3'd2;
    localparam logic [2:0] POS_B2   = 3'd3;
    localparam logic [2:0] POS_B3   = 3'd4;
    localparam logic [2:0] POS_B4   = 3'd5;

    logic [23:0] hist_reg, hist_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  kept_reg, kept_next;
    fields_t     held_reg, held_next;
    logic        is_code;

    assign is_code = (hist_reg == CODE_PREFIX);

    always_comb
    begin
        pos_next  = pos_reg;
        kept_next = kept_reg;
        held_next = held_reg;
        if (is_code && data_byte == PIC_CODE)
        begin
            pos_next = POS_B0;
        end
        else
        begin
            case (pos_reg)
                POS_IDLE:
                begin
                    pos_next = POS_IDLE;
                end
                POS_B0:
                begin
                    kept_next = data_byte;
                    pos_next  = POS_B1;
                end
                POS_B1:
                begin
                    held_next.temp_ref     = {kept_reg, data_byte[7:6]};
                    held_next.picture_type = data_byte[5:3];
                    pos_next               = POS_B2;
                end
                POS_B2:
                begin
                    pos_next = POS_B3;
                end
                POS_B3:
                begin
                    kept_next = data_byte;
                    pos_next  = POS_B4;
                end
                POS_B4:
                begin
                    if (held_reg.picture_type == TYPE_P || held_reg.picture_type == TYPE_B)
                    begin
                        held_next.full_pel_forward = kept_reg[2];
                        held_next.forward_code     = {kept_reg[1:0], data_byte[7]};
                    end
                    if (held_reg.picture_type == TYPE_B)
                    begin
                        held_next.full_pel_backward = data_byte[6];
                        held_next.backward_code     = data_byte[5:3];
                    end
                    pos_next = POS_IDLE;
                end
                default:
                begin
                    pos_next = POS_IDLE;
                end
            endcase
            if (is_code && data_byte == SEQ_CODE)
            begin
                held_next.sequence_start = 1'b1;
            end
        end
        hist_next = is_code ? HIST_RESET : {hist_reg[15:0], data_byte};
    end

    // result carries the fields after this byte is taken in
    assign fields = held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= HIST_RESET;
            pos_reg  <= POS_IDLE;
            kept_reg <= '0;
            held_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // frame done: start the next one from scratch
                hist_reg <= HIST_RESET;
                pos_reg  <= POS_IDLE;
                kept_reg <= '0;
                held_reg <= '0;
            end
            else
            begin
                hist_reg <= hist_next;
                pos_reg  <= pos_next;
                kept_reg <= kept_next;
                held_reg <= held_next;
            end
        end
    end

endmodule

[sv/mvph_out_reg.sv]
`timescale 1ns / 1ps
// mvph_out_reg: result register with valid/ready hold.
// Depends on mvph_pkg.
module mvph_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mvph_pkg::fields_t fields_in,
    input  logic              ready,
    output logic              valid,
    output mvph_pkg::fields_t fields_out
);
    import mvph_pkg::*;

    logic    valid_reg, valid_next;
    fields_t data_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= fields_in;
        end
    end

    assign valid      = valid_reg;
    assign fields_out = data_reg;

endmodule

[sv/mpeg_video_picture_header_parser_core.sv]
`timescale 1ns / 1ps
// A frame's last byte waits in the input register until the result register is free, then loads its result.
// Throughput: one byte per cycle; a stalled result holds back only a following last byte.
// The input register, parse state and result register form the path; ready ripples back.
// Reset (rst_n low, asynchronous): history all ones, capture idle, held fields zero,
// both register stages empty.
// Top level of the MPEG video picture header parser. Depends on mvph_pkg,
// mvph_parser and mvph_out_reg.
module mpeg_video_picture_header_parser_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [9:0] temp_ref,
    output logic [2:0] picture_type,
    output logic       sequence_start,
    output logic       full_pel_forward,
    output logic [2:0] forward_code,
    output logic       full_pel_backward,
    output logic [2:0] backward_code
);
    import mvph_pkg::*;

    // Input register: one byte held ahead of the parse logic
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    logic       s1_advance;   // held byte moves into the parse state this cycle
    logic       out_load;     // held byte ends a frame and fills the result register
    logic       out_free;     // result register can take a new result
    fields_t    parse_fields;
    fields_t    res_fields;

    // Only a frame's last byte needs room at the output; others always advance.
    assign out_free   = !out_valid || out_ready;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign out_load   = s1_advance && s1_last_reg;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Start code scan and header capture
    mvph_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_advance),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .fields    (parse_fields)
    );

    // Result register
    mvph_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .fields_in  (parse_fields),
        .ready      (out_ready),
        .valid      (out_valid),
        .fields_out (res_fields)
    );

    assign temp_ref          = res_fields.temp_ref;
    assign picture_type      = res_fields.picture_type;
    assign sequence_start    = res_fields.sequence_start;
    assign full_pel_forward  = res_fields.full_pel_forward;
    assign forward_code      = res_fields.forward_code;
    assign full_pel_backward = res_fields.full_pel_backward;
    assign backward_code     = res_fields.backward_code;

`ifndef ASSERT_OFF
    // A non-final byte is never held back by the output side
    a_nonlast_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_last_reg |-> s1_advance)
        else $error("non-final byte stalled in input register");

    // A final byte waiting on a full output stays put
    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && out_valid && !out_ready |=> s1_valid_reg && s1_last_reg)
        else $error("final byte dropped while result stalled");

    // A result is loaded only when the previous one has gone or is going
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid || out_ready)
        else $error("result register overwritten");

    // Every load shows up as a valid result next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule

[test/mpeg_video_picture_header_parser_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for mpeg_video_picture_header_parser_core: byte frames go in,
// and each frame's picture header fields are checked against a built-in header predictor.
// Depends on mvph_pkg and the parser RTL.
module mpeg_video_picture_header_parser_core_tb;

    import mvph_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int BYTE_TARGET  = 850;
    localparam int STALL_LIMIT  = 400;   // cycles with no transfer on either side
    localparam int TAIL_CYCLES  = 10;    // wait after the last result is checked

    // Where the predictor stands within a picture header
    typedef enum logic [2:0] {
        HDR_IDLE,
        HDR_BYTE0,
        HDR_BYTE1,
        HDR_BYTE2,
        HDR_BYTE3,
        HDR_BYTE4
    } hdr_pos_e;

    localparam logic [2:0] TYPE_I = 3'd1;

    // Header predictor and store of expected frame results
    class header_scoreboard;
        logic [23:0]  history;
        hdr_pos_e     hdr_pos;
        logic [7:0]   kept;
        logic [9:0]   tref;
        logic [2:0]   ptype;
        logic         seq_seen;
        logic [3:0]   fwd_fields;
        logic [3:0]   bwd_fields;
        fields_t      frames_due[$];
        int unsigned  mismatches;
        int unsigned  frames_checked;

        function new();
            mismatches     = 0;
            frames_checked = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            history    = HIST_RESET;
            hdr_pos    = HDR_IDLE;
            kept       = '0;
            tref       = '0;
            ptype      = '0;
            seq_seen   = 1'b0;
            fwd_fields = '0;
            bwd_fields = '0;
        endfunction

        // Called for every byte transferred into the block
        function void note_byte(logic [7:0] b, logic last);
            fields_t exp_fields;
            logic    at_code;
            at_code = (history == CODE_PREFIX);
            if (at_code && b == PIC_CODE) begin
                hdr_pos = HDR_BYTE0;
            end
            else begin
                case (hdr_pos)
                    HDR_BYTE0:
                    begin
                        kept    = b;
                        hdr_pos = HDR_BYTE1;
                    end
                    HDR_BYTE1:
                    begin
                        tref    = {kept, b[7:6]};
                        ptype   = b[5:3];
                        hdr_pos = HDR_BYTE2;
                    end
                    HDR_BYTE2:
                    begin
                        hdr_pos = HDR_BYTE3;
                    end
                    HDR_BYTE3:
                    begin
                        kept    = b;
                        hdr_pos = HDR_BYTE4;
                    end
                    HDR_BYTE4:
                    begin
                        if (ptype == TYPE_P || ptype == TYPE_B)
                            fwd_fields = {kept[2], kept[1:0], b[7]};
                        if (ptype == TYPE_B)
                            bwd_fields = {b[6], b[5:3]};
                        hdr_pos = HDR_IDLE;
                    end
                    default:
                    begin
                        hdr_pos = HDR_IDLE;
                    end
                endcase
                if (at_code && b == SEQ_CODE)
                    seq_seen = 1'b1;
            end
            history = at_code ? HIST_RESET : {history[15:0], b};
            if (last) begin
                exp_fields.temp_ref          = tref;
                exp_fields.picture_type      = ptype;
                exp_fields.sequence_start    = seq_seen;
                exp_fields.full_pel_forward  = fwd_fields[3];
                exp_fields.forward_code      = fwd_fields[2:0];
                exp_fields.full_pel_backward = bwd_fields[3];
                exp_fields.backward_code     = bwd_fields[2:0];
                frames_due.push_back(exp_fields);
                clear_frame();
            end
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        // Called for every result transferred out of the block
        function void check_result(fields_t got);
            fields_t want;
            if (frames_due.size() == 0) begin
                $error("result with no frame outstanding: %h", got);
                mismatches++;
                return;
            end
            want = frames_due.pop_front();
            frames_checked++;
            compare_field("temp_ref", want.temp_ref, got.temp_ref);
            compare_field("picture_type", want.picture_type, got.picture_type);
            compare_field("sequence_start", want.sequence_start, got.sequence_start);
            compare_field("full_pel_forward", want.full_pel_forward, got.full_pel_forward);
            compare_field("forward_code", want.forward_code, got.forward_code);
            compare_field("full_pel_backward", want.full_pel_backward,
                          got.full_pel_backward);
            compare_field("backward_code", want.backward_code, got.backward_code);
        endfunction

        function int pending();
            return frames_due.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_ready;
    logic [9:0] temp_ref;
    logic [2:0] picture_type;
    logic       sequence_start;
    logic       full_pel_forward;
    logic [2:0] forward_code;
    logic       full_pel_backward;
    logic [2:0] backward_code;

    header_scoreboard sb;
    logic [7:0]       frame_bytes[$];
    int unsigned      bytes_sent;
    int unsigned      frames_sent;
    int unsigned      pictures_built;
    bit               tx_steady;     // frame sent with no gaps between bytes
    bit               rx_steady;     // results taken with no stall

    mpeg_video_picture_header_parser_core dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .data_byte          (data_byte),
        .last_byte          (last_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .temp_ref           (temp_ref),
        .picture_type       (picture_type),
        .sequence_start     (sequence_start),
        .full_pel_forward   (full_pel_forward),
        .forward_code       (forward_code),
        .full_pel_backward  (full_pel_backward),
        .backward_code      (backward_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Frame building: bytes are queued first, then sent as one frame
    // ---------------------------------------------------------------
    task automatic add_code(logic [7:0] code);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(code);
    endtask

    // Picture start code plus up to five header bytes of the given coding type
    task automatic add_picture(int n_hdr, logic [2:0] ptype);
        logic [7:0] hdr[5];
        hdr[0] = 8'($urandom_range(0, 255));
        hdr[1] = {2'($urandom_range(0, 3)), ptype, 3'($urandom_range(0, 7))};
        hdr[2] = 8'($urandom_range(0, 255));
        hdr[3] = 8'($urandom_range(0, 255));
        hdr[4] = 8'($urandom_range(0, 255));
        add_code(PIC_CODE);
        for (int i = 0; i < n_hdr; i++)
            frame_bytes.push_back(hdr[i]);
        pictures_built++;
    endtask

    // Noise leans on 00 and 01 so that stray and overlapping prefixes turn up
    task automatic add_noise(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                frame_bytes.push_back(8'h00);
            else if (pick == 1)
                frame_bytes.push_back(8'h01);
            else
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // One byte transfer; valid stays high between back-to-back bytes
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
        frames_sent++;
    endtask

    // Random frame: mostly well-formed segments, some noise and cut headers
    task automatic build_random_frame();
        int n_segs;
        int kind;
        int cut;
        logic [2:0] ptype;
        n_segs = $urandom_range(1, 4);
        for (int s = 0; s < n_segs; s++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: add_code(SEQ_CODE);
                2, 3, 4, 5, 6:
                begin
                    case ($urandom_range(0, 3))
                        0:       ptype = TYPE_I;
                        1:       ptype = TYPE_P;
                        2:       ptype = TYPE_B;
                        default: ptype = 3'($urandom_range(0, 7));
                    endcase
                    add_picture(5, ptype);
                end
                7: add_noise($urandom_range(1, 6));
                8: add_picture($urandom_range(0, 4), 3'($urandom_range(0, 7)));
                default: add_code(8'($urandom_range(1, 255)));
            endcase
        end
        // sometimes the frame ends early, mid header or mid code
        if ($urandom_range(0, 5) == 0 && frame_bytes.size() > 1) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            repeat (cut) void'(frame_bytes.pop_back());
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, then check each transfer
    // ---------------------------------------------------------------
    initial
    begin : result_side
        int      gap;
        fields_t got;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 7) == 0)
                rx_steady = ~rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.temp_ref          = temp_ref;
            got.picture_type      = picture_type;
            got.sequence_start    = sequence_start;
            got.full_pel_forward  = full_pel_forward;
            got.forward_code      = forward_code;
            got.full_pel_backward = full_pel_backward;
            got.backward_code     = backward_code;
            sb.check_result(got);
        end
    end

    // Watchdog: ends the run if neither side transfers for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        sb             = new();
        bytes_sent     = 0;
        frames_sent    = 0;
        pictures_built = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        last_byte      = 1'b0;
        out_ready      = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Single-byte frame: nothing seen, all fields zero
        frame_bytes.push_back(8'hFF);
        send_frame();

        // Sequence code then a complete B picture with every header bit set
        // apart from the type, so all fields reach their maximum
        add_code(SEQ_CODE);
        add_code(PIC_CODE);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back({2'b11, TYPE_B, 3'b111});
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hFF);
        send_frame();

        // Picture code arriving inside a header restarts capture; the frame
        // then ends right after header byte 1, so the vector fields stay clear
        add_code(PIC_CODE);
        frame_bytes.push_back(8'h00);
        add_code(PIC_CODE);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back({2'b00, TYPE_P, 3'b000});
        send_frame();

        // Random frames; one in four with no gaps, and now and then a full drain
        while (bytes_sent < BYTE_TARGET) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            build_random_frame();
            send_frame();
            if (frames_sent % 16 == 7) begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d frames (%0d picture headers started)",
                 bytes_sent, frames_sent, pictures_built);
        $display("Checked %0d frame results, %0d field mismatches",
                 sb.frames_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
